@@ rtl/core/gbrl_pkg.sv @@
// ----------------------------------------------------------------------------
// gbrl_pkg
// Shared types, constants and helpers of the ghost box rank lookup.
// ----------------------------------------------------------------------------
package gbrl_pkg;

  // default table depth and the dimension limit of the box store
  localparam int unsigned MaxBoxesDef = 16;
  localparam int unsigned MaxDims     = 3;

  // register reset values
  localparam logic [1:0] NumDimsRst = 2'd3;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgNumDims  = 2'd0,
    CfgNumBoxes = 2'd1,
    CfgRankBase = 2'd2
  } cfg_idx_e;

  // request kinds carried in tuser
  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqQuery = 1'b1;

  typedef logic [2:0][31:0] trip_t;
  typedef logic [2:0][32:0] wtrip_t;

  // one item as it moves through the front stages
  typedef struct packed {
    logic        req_type;
    logic [3:0]  slot;
    trip_t       lo;
    trip_t       hi;
    trip_t       idx;
    wtrip_t      w;     // widened sizes
    logic [63:0] m01;   // w0 * w1
    logic [63:0] vh;    // low half of m01 times w2
    logic [31:0] hl;    // high half of m01 times w2, low 32 bits
    logic [63:0] vol3;  // w0 * w1 * w2
  } stage_t;

  // selected box of a query, handed from the box table to the offset path
  typedef struct packed {
    logic        hit;
    logic [1:0]  nd;
    wtrip_t      t;     // index minus widened lower corner
    logic [32:0] w0;
    logic [32:0] w1;
  } sel_t;

  // widened extent: max(hi - lo + 1, 0) + 2
  function automatic logic [32:0] widen_size(logic [31:0] lo, logic [31:0] hi);
    logic [33:0] diff;
    diff = {hi[31], hi[31], hi} - {lo[31], lo[31], lo} + 34'd1;
    if (diff[33]) begin
      widen_size = 33'd2;
    end else begin
      widen_size = diff[32:0] + 33'd2;
    end
  endfunction

endpackage

@@ rtl/core/ghost_box_rank_lookup_top.sv @@
// ----------------------------------------------------------------------------
// ghost_box_rank_lookup_top
// Ghost-widened box table with rank lookup of a grid index.
// ----------------------------------------------------------------------------
// Fully pipelined: one item per cycle is accepted while the output side takes
// results. A load writes its box slot after the accept, widen, w0*w1, times-w2
// and volume stages; a query tests the first num_boxes lanes in parallel against
// the stored lanes, then a registered adder tree sums the volumes ahead of the
// hit box. Loads produce no result. A stalled output holds the whole pipeline.
module ghost_box_rank_lookup_top
  import gbrl_pkg::*;
#(
  parameter int unsigned MAX_BOXES = MaxBoxesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // box_slot[3:0], lo_0, lo_1, lo_2, hi_0, hi_1, hi_2, idx_0, idx_1, idx_2, zero pad
  input  logic [295:0] s_axis_tdata,
  // req_type
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rank_out
  output logic [63:0]  m_axis_tdata,
  // hit
  output logic         m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [62:0]  cfg_data_i
);

  localparam int unsigned NPAD = (MAX_BOXES <= 16) ? 16 : (2 ** $clog2(MAX_BOXES));
  localparam int unsigned LVL  = $clog2(NPAD);
  localparam int unsigned DLY  = LVL - 4;

  // configuration registers
  logic [1:0]  num_dims_q;
  logic [4:0]  num_boxes_q;
  logic [62:0] rank_base_q;
  logic [1:0]  nd_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q  <= NumDimsRst;
      num_boxes_q <= '0;
      rank_base_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgNumDims:  num_dims_q  <= cfg_data_i[1:0];
        CfgNumBoxes: num_boxes_q <= cfg_data_i[4:0];
        CfgRankBase: rank_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign nd_eff = (num_dims_q > 2'(MaxDims)) ? 2'(MaxDims) : num_dims_q;

  // global advance: the output register is free or being taken
  logic en;
  logic out_valid_q;
  assign en            = ~out_valid_q | m_axis_tready;
  assign s_axis_tready = en;

  // front stages: accept, widened sizes, w0*w1, times w2, volume
  logic   v1_q, v2_q, v3_q, v4_q, v5_q;
  stage_t s1_q, s2_q, s3_q, s4_q, s5_q;
  stage_t s1_d, s2_d, s3_d, s4_d, s5_d;
  logic [65:0] m01_full;
  logic [64:0] vh_full;
  logic [63:0] hl_full;

  always_comb begin
    s1_d          = s1_q;
    s1_d.req_type = s_axis_tuser;
    s1_d.slot     = s_axis_tdata[3:0];
    s1_d.lo[0]    = s_axis_tdata[35:4];
    s1_d.lo[1]    = s_axis_tdata[67:36];
    s1_d.lo[2]    = s_axis_tdata[99:68];
    s1_d.hi[0]    = s_axis_tdata[131:100];
    s1_d.hi[1]    = s_axis_tdata[163:132];
    s1_d.hi[2]    = s_axis_tdata[195:164];
    s1_d.idx[0]   = s_axis_tdata[227:196];
    s1_d.idx[1]   = s_axis_tdata[259:228];
    s1_d.idx[2]   = s_axis_tdata[291:260];

    s2_d = s1_q;
    for (int d = 0; d < 3; d++) begin
      s2_d.w[d] = widen_size(s1_q.lo[d], s1_q.hi[d]);
    end

    s3_d     = s2_q;
    m01_full = 66'(s2_q.w[0]) * 66'(s2_q.w[1]);
    s3_d.m01 = m01_full[63:0];

    s4_d    = s3_q;
    vh_full = 65'(s3_q.m01[31:0]) * 65'(s3_q.w[2]);
    hl_full = 64'(s3_q.m01[63:32]) * 64'(s3_q.w[2][31:0]);
    s4_d.vh = vh_full[63:0];
    s4_d.hl = hl_full[31:0];

    s5_d      = s4_q;
    s5_d.vol3 = s4_q.vh + {s4_q.hl, 32'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
      s5_q <= s5_d;
    end
  end

  // box lanes, containment and volume masking
  logic        v6;
  sel_t        sel6;
  logic [63:0] leaf [NPAD];

  gbrl_box_table #(
    .NBOX (MAX_BOXES),
    .NPAD (NPAD)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v5_q),
    .st_i    (s5_q),
    .nd_i    (nd_eff),
    .nb_i    (num_boxes_q),
    .valid_o (v6),
    .sel_o   (sel6),
    .vol_o   (leaf)
  );

  // registered adder tree, node k sums children 2k and 2k+1
  logic [63:0] tree_q [1:NPAD-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 1; k < NPAD; k++) begin
        if (2 * k >= NPAD) begin
          tree_q[k] <= leaf[(2 * k - NPAD) % NPAD] + leaf[(2 * k + 1 - NPAD) % NPAD];
        end else begin
          tree_q[k] <= tree_q[2 * k] + tree_q[2 * k + 1];
        end
      end
    end
  end

  // offset path: t2*w1, +t1, *w0, +t0
  logic        o1_hit, o2_hit, o3_hit, o4_hit;
  logic [1:0]  o1_nd, o2_nd, o3_nd;
  logic [32:0] o1_t0, o1_t1, o1_w0, o2_t0, o2_w0, o3_t0;
  logic [63:0] o1_p, o2_a, o3_ml, o4_off;
  logic [31:0] o3_mh;
  logic [4:0]  ov_q;
  logic [65:0] p_full;
  logic [64:0] ml_full;
  logic [63:0] mh_full;
  logic [63:0] a_d, off_d;

  assign p_full  = 66'(sel6.t[2]) * 66'(sel6.w1);
  assign ml_full = 65'(o2_a[31:0]) * 65'(o2_w0);
  assign mh_full = 64'(o2_a[63:32]) * 64'(o2_w0[31:0]);

  always_comb begin
    case (o1_nd)
      2'd3:    a_d = o1_p + {31'b0, o1_t1};
      2'd2:    a_d = {31'b0, o1_t1};
      default: a_d = 64'd0;
    endcase
    off_d = 64'd0;
    if (o3_nd >= 2'd2) begin
      off_d = o3_ml + {o3_mh, 32'b0};
    end
    if (o3_nd != 2'd0) begin
      off_d = off_d + {31'b0, o3_t0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= '0;
    end else if (en) begin
      ov_q <= {ov_q[3:0], v6};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o1_hit <= sel6.hit;
      o1_nd  <= sel6.nd;
      o1_t0  <= sel6.t[0];
      o1_t1  <= sel6.t[1];
      o1_w0  <= sel6.w0;
      o1_p   <= p_full[63:0];

      o2_hit <= o1_hit;
      o2_nd  <= o1_nd;
      o2_t0  <= o1_t0;
      o2_w0  <= o1_w0;
      o2_a   <= a_d;

      o3_hit <= o2_hit;
      o3_nd  <= o2_nd;
      o3_t0  <= o2_t0;
      o3_ml  <= ml_full[63:0];
      o3_mh  <= mh_full[31:0];

      o4_hit <= o3_hit;
      o4_off <= off_d;
    end
  end

  // delay to match the tree depth
  logic        dv_q   [DLY+1];
  logic        dhit_q [DLY+1];
  logic [63:0] doff_q [DLY+1];

  always_comb begin
    dv_q[0]   = ov_q[3];
    dhit_q[0] = o4_hit;
    doff_q[0] = o4_off;
  end

  for (genvar i = 1; i <= DLY; i++) begin : g_dly
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[i] <= 1'b0;
      end else if (en) begin
        dv_q[i] <= dv_q[i-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dhit_q[i] <= dhit_q[i-1];
        doff_q[i] <= doff_q[i-1];
      end
    end
  end

  // output register
  logic [63:0] out_rank_q;
  logic        out_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_q[DLY];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_hit_q  <= dhit_q[DLY];
      out_rank_q <= dhit_q[DLY] ? (tree_q[1] + doff_q[DLY] + {1'b0, rank_base_q})
                                : '1;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_rank_q;
  assign m_axis_tuser  = out_hit_q;

endmodule

@@ rtl/core/gbrl_box_table.sv @@
// ----------------------------------------------------------------------------
// gbrl_box_table
// Box lanes with their precomputed volumes, parallel containment test,
// first-hit selection and masking of the volumes ahead of the hit box.
// ----------------------------------------------------------------------------
module gbrl_box_table
  import gbrl_pkg::*;
#(
  parameter int unsigned NBOX = MaxBoxesDef,
  parameter int unsigned NPAD = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  stage_t      st_i,
  input  logic [1:0]  nd_i,
  input  logic [4:0]  nb_i,
  output logic        valid_o,
  output sel_t        sel_o,
  output logic [63:0] vol_o [NPAD]
);

  // lane storage, written by loads, no reset
  trip_t       lo_q   [NBOX];
  trip_t       hi_q   [NBOX];
  wtrip_t      w_q    [NBOX];
  logic [63:0] vol2_q [NBOX];
  logic [63:0] vol3_q [NBOX];

  logic        we;
  logic        is_q;
  logic [33:0] tdiff [NBOX][3];
  logic [33:0] udiff [NBOX][3];
  logic [NBOX-1:0] hitv;
  logic [NBOX-1:0] seen;
  logic [NBOX-1:0] first;
  logic [63:0] volsel [NBOX];
  sel_t        sel_d;

  logic        valid_q;
  sel_t        sel_q;
  logic [63:0] vol_q [NBOX];

  assign we   = en_i & valid_i & (st_i.req_type == ReqLoad);
  assign is_q = valid_i & (st_i.req_type == ReqQuery);

  // load write
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < NBOX; j++) begin
      if (we && ({5'b0, st_i.slot} == 9'(j))) begin
        lo_q[j]   <= st_i.lo;
        hi_q[j]   <= st_i.hi;
        w_q[j]    <= st_i.w;
        vol2_q[j] <= st_i.m01;
        vol3_q[j] <= st_i.vol3;
      end
    end
  end

  // containment per lane and per dimension
  always_comb begin
    for (int j = 0; j < NBOX; j++) begin
      logic inb;
      inb = 1'b1;
      for (int d = 0; d < 3; d++) begin
        tdiff[j][d] = {st_i.idx[d][31], st_i.idx[d][31], st_i.idx[d]}
                    - {lo_q[j][d][31], lo_q[j][d][31], lo_q[j][d]} + 34'd1;
        udiff[j][d] = {hi_q[j][d][31], hi_q[j][d][31], hi_q[j][d]} + 34'd1
                    - {st_i.idx[d][31], st_i.idx[d][31], st_i.idx[d]};
        if ((tdiff[j][d][33] || udiff[j][d][33]) && (2'(d) < nd_i)) begin
          inb = 1'b0;
        end
      end
      hitv[j] = is_q & inb & (9'(j) < {4'b0, nb_i});
      case (nd_i)
        2'd0:    volsel[j] = 64'd1;
        2'd1:    volsel[j] = {31'b0, w_q[j][0]};
        2'd2:    volsel[j] = vol2_q[j];
        default: volsel[j] = vol3_q[j];
      endcase
    end
  end

  // first hit and one-hot select of its box
  always_comb begin
    sel_d = '0;
    for (int j = 0; j < NBOX; j++) begin
      if (j == 0) begin
        seen[j]  = hitv[j];
        first[j] = hitv[j];
      end else begin
        seen[j]  = seen[j-1] | hitv[j];
        first[j] = hitv[j] & ~seen[j-1];
      end
      if (first[j]) begin
        sel_d.t[0] = tdiff[j][0][32:0];
        sel_d.t[1] = tdiff[j][1][32:0];
        sel_d.t[2] = tdiff[j][2][32:0];
        sel_d.w0   = w_q[j][0];
        sel_d.w1   = w_q[j][1];
      end
    end
    sel_d.hit = |hitv;
    sel_d.nd  = nd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= is_q;
    end
  end

  // volumes of the boxes ahead of the hit, zero from the hit on
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sel_q <= sel_d;
      for (int j = 0; j < NBOX; j++) begin
        vol_q[j] <= seen[j] ? 64'd0 : volsel[j];
      end
    end
  end

  assign valid_o = valid_q;
  assign sel_o   = sel_q;

  always_comb begin
    for (int j = 0; j < NPAD; j++) begin
      vol_o[j] = (j < NBOX) ? vol_q[j % NBOX] : 64'd0;
    end
  end

endmodule

@@ bench/tb_ghost_box_rank_lookup_top.sv @@
// ----------------------------------------------------------------------------
// tb_ghost_box_rank_lookup_top
// Self-checking bench for the ghost box rank lookup: loads box tables, writes
// the registers between phases, queries indexes around widened boxes, and
// checks every rank and hit flag against a behavioral predictor or a typed row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ghost_box_rank_lookup_top;
  import gbrl_pkg::*;

  localparam int NBox = 16;
  localparam int WatchLimit = 4000;
  localparam int DrainCycles = 40;

  typedef struct {
    logic        req;
    logic [3:0]  slot;
    logic [31:0] lo[3];
    logic [31:0] hi[3];
    logic [31:0] idx[3];
  } item_t;

  typedef struct {
    logic [63:0] rank;
    logic        hit;
  } rank_res_t;

  // directed table row: item plus optional typed expectation
  typedef struct {
    item_t       it;
    logic        has_exp;
    logic [63:0] exp_rank;
    logic        exp_hit;
  } row_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [295:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [63:0] m_axis_tdata;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [62:0] cfg_data_i;

  ghost_box_rank_lookup_top u_top (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // predictor state
  logic [1:0]  pr_dims;
  logic [4:0]  pr_boxes;
  logic [62:0] pr_base;
  logic [31:0] tbl_lo[NBox][3];
  logic [31:0] tbl_hi[NBox][3];
  bit          loaded[NBox];

  rank_res_t pending_ranks[$];
  int  errors = 0, n_items = 0, n_results = 0, n_hits = 0, idle_cycles = 0;
  bit  quiet = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // widened extent of one box dimension, 64-bit
  function automatic logic [63:0] wsize(logic [31:0] lo, logic [31:0] hi);
    longint s;
    s = longint'($signed(hi)) - longint'($signed(lo)) + 1;
    if (s < 0) s = 0;
    return 64'(s) + 64'd2;
  endfunction

  function automatic rank_res_t predict_rank(item_t it);
    rank_res_t r;
    int nd, nb;
    logic [63:0] acc, vol;
    longint x;
    bit ins;
    nd = (pr_dims > 3) ? 3 : pr_dims;
    nb = (pr_boxes > NBox) ? NBox : pr_boxes;
    acc = {1'b0, pr_base};
    r.rank = '1;
    r.hit = 1'b0;
    for (int b = 0; b < nb; b++) begin
      ins = 1;
      for (int d = 0; d < nd; d++) begin
        x = longint'($signed(it.idx[d]));
        if (x < longint'($signed(tbl_lo[b][d])) - 1 ||
            x > longint'($signed(tbl_hi[b][d])) + 1) ins = 0;
      end
      if (ins) begin
        vol = 0;
        for (int d = nd - 1; d >= 0; d--)
          vol = vol * wsize(tbl_lo[b][d], tbl_hi[b][d]) +
                64'(longint'($signed(it.idx[d])) - longint'($signed(tbl_lo[b][d])) + 1);
        r.rank = acc + vol;
        r.hit = 1'b1;
        return r;
      end
      vol = 1;
      for (int d = 0; d < nd; d++) vol = vol * wsize(tbl_lo[b][d], tbl_hi[b][d]);
      acc = acc + vol;
    end
    return r;
  endfunction

  // random idle burst, none in the quiet tail
  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 9)) @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [62:0] val);
    cfg_index_i = idx;
    cfg_data_i  = val;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    case (idx)
      CfgNumDims:  pr_dims  = val[1:0];
      CfgNumBoxes: pr_boxes = val[4:0];
      default:     pr_base  = val;
    endcase
  endtask

  // send one item; a typed expectation overrides the predictor
  task automatic send_item(item_t it, bit has_exp = 0, rank_res_t ex = '{0, 0});
    rank_res_t r;
    maybe_idle();
    s_axis_tuser  = it.req;
    s_axis_tdata  = {4'd0, it.idx[2], it.idx[1], it.idx[0], it.hi[2], it.hi[1], it.hi[0],
                     it.lo[2], it.lo[1], it.lo[0], it.slot};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    n_items++;
    if (it.req == ReqLoad) begin
      for (int d = 0; d < 3; d++) begin
        tbl_lo[it.slot][d] = it.lo[d];
        tbl_hi[it.slot][d] = it.hi[d];
      end
      loaded[it.slot] = 1;
    end else begin
      r = predict_rank(it);
      pending_ranks.push_back(has_exp ? ex : r);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // wait for all results plus pipeline drain
  task automatic settle();
    while (pending_ranks.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    rank_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (pending_ranks.size() == 0) begin
        $display("%0t: unexpected result rank=%h hit=%b", $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        e = pending_ranks.pop_front();
        if (m_axis_tuser) n_hits++;
        if (m_axis_tdata !== e.rank) begin
          $display("%0t: rank mismatch expected %h actual %h", $time, e.rank, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== e.hit) begin
          $display("%0t: hit mismatch expected %b actual %b", $time, e.hit, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any transfer while results are pending
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || pending_ranks.size() == 0)
      idle_cycles = 0;
    else if (++idle_cycles >= WatchLimit) begin
      $display("ghost_box_rank_lookup_top test failed");
      $finish;
    end
  end

  function automatic item_t mk_box(int slot, int l0, int l1, int l2, int h0, int h1, int h2);
    item_t it;
    it.req = ReqLoad;
    it.slot = slot[3:0];
    it.lo = '{l0, l1, l2};
    it.hi = '{h0, h1, h2};
    it.idx = '{$urandom, $urandom, $urandom};
    return it;
  endfunction

  function automatic item_t mk_query(int i0, int i1, int i2);
    item_t it;
    it.req = ReqQuery;
    it.slot = 4'($urandom);
    it.lo = '{$urandom, $urandom, $urandom};
    it.hi = '{$urandom, $urandom, $urandom};
    it.idx = '{i0, i1, i2};
    return it;
  endfunction

  // random box: mostly small, sometimes extreme or empty
  function automatic item_t rand_box(int slot);
    int l[3], h[3];
    for (int d = 0; d < 3; d++) begin
      case ($urandom_range(0, 9))
        0: begin l[d] = $urandom; h[d] = $urandom; end
        1: begin l[d] = 32'h8000_0000; h[d] = 32'h7fff_ffff; end
        2: begin l[d] = $urandom_range(0, 20); h[d] = l[d] - $urandom_range(1, 5); end
        default: begin l[d] = int'($urandom_range(0, 40)) - 20; h[d] = l[d] + $urandom_range(0, 6); end
      endcase
    end
    return mk_box(slot, l[0], l[1], l[2], h[0], h[1], h[2]);
  endfunction

  // random query: mostly near a loaded box, including ghost layer
  function automatic item_t rand_query(int nb);
    int b, i[3];
    b = (nb > 0) ? $urandom_range(0, nb - 1) : 0;
    for (int d = 0; d < 3; d++) begin
      if ($urandom_range(0, 4) == 0 || !loaded[b]) i[d] = $urandom;
      else if ($urandom_range(0, 3) == 0)
        i[d] = $urandom_range(0, 1) ? int'(tbl_lo[b][d]) - 1 : int'(tbl_hi[b][d]) + 1;
      else
        i[d] = int'(tbl_lo[b][d]) - 1 + int'($urandom_range(0, 8));
    end
    return mk_query(i[0], i[1], i[2]);
  endfunction

  row_t dir_rows[$];

  initial begin
    item_t it;
    row_t rw;
    int nb;
    s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = 0;
    cfg_valid_i = 0; cfg_index_i = CfgNumDims; cfg_data_i = '0;
    pr_dims = NumDimsRst; pr_boxes = 0; pr_base = 0;
    rst_ni = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: reset state misses, then extremes of the corners
    rw = '{mk_query(0, 0, 0), 1, '1, 0};                          dir_rows.push_back(rw);
    rw = '{mk_query(32'h8000_0000, 32'h7fff_ffff, -1), 1, '1, 0}; dir_rows.push_back(rw);
    rw = '{mk_box(0, 0, 0, 0, 0, 0, 0), 0, 0, 0};                  dir_rows.push_back(rw);
    rw = '{mk_box(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 0, 0, 0}; dir_rows.push_back(rw);
    rw = '{mk_box(2, 5, 5, 5, 2, 2, 2), 0, 0, 0};                  dir_rows.push_back(rw);
    rw = '{mk_box(15, -3, -3, -3, 3, 3, 3), 0, 0, 0};              dir_rows.push_back(rw);
    foreach (dir_rows[k]) send_item(dir_rows[k].it, dir_rows[k].has_exp,
                                    '{dir_rows[k].exp_rank, dir_rows[k].exp_hit});
    settle();
    for (int s = 3; s < 15; s++) send_item(rand_box(s));
    settle();
    cfg_write(CfgNumBoxes, 63'd16);
    cfg_write(CfgRankBase, 63'd0);
    dir_rows.delete();
    // lower ghost corner of box 0 is offset 0
    rw = '{mk_query(-1, -1, -1), 1, 64'd0, 1};                     dir_rows.push_back(rw);
    rw = '{mk_query(1, 1, 1), 1, 64'd26, 1};                       dir_rows.push_back(rw);
    rw = '{mk_query(0, 0, 0), 0, 0, 0};                            dir_rows.push_back(rw);
    rw = '{mk_query(32'h8000_0000, 0, 32'h7fff_ffff), 0, 0, 0};    dir_rows.push_back(rw);
    rw = '{mk_query(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 0, 0, 0}; dir_rows.push_back(rw);
    rw = '{mk_query(6, 6, 6), 0, 0, 0};                            dir_rows.push_back(rw);
    rw = '{mk_query(-4, 4, 0), 0, 0, 0};                           dir_rows.push_back(rw);
    foreach (dir_rows[k]) send_item(dir_rows[k].it, dir_rows[k].has_exp,
                                    '{dir_rows[k].exp_rank, dir_rows[k].exp_hit});
    settle();
    // zero dims hits box 0 at rank_base; max base
    cfg_write(CfgNumDims, 63'd0);
    cfg_write(CfgRankBase, 63'h7fff_ffff_ffff_ffff);
    send_item(mk_query($urandom, $urandom, $urandom), 1, '{64'h7fff_ffff_ffff_ffff, 1});
    settle();
    cfg_write(CfgNumDims, 63'd1);
    send_item(mk_query(32'h7fff_ffff, 0, 0));
    send_item(mk_query(32'h8000_0000, 0, 0));
    settle();

    // random phases over several register settings
    for (int ph = 0; ph < 9; ph++) begin
      settle();
      if (ph == 8) quiet = 1;
      cfg_write(CfgNumDims, 63'($urandom_range(0, 3)));
      nb = (ph % 3 == 0) ? 16 : $urandom_range(0, 16);
      cfg_write(CfgNumBoxes, 63'(nb));
      cfg_write(CfgRankBase, ph == 1 ? 63'h7fff_ffff_ffff_ffff :
                             ph == 2 ? 63'd0 : 63'({$urandom, $urandom}));
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 9) < 2) send_item(rand_box($urandom_range(0, 15)));
        else send_item(rand_query(nb));
      end
    end
    settle();

    $display("Sent %0d items (box loads and queries), checked %0d results, %0d hits.",
             n_items, n_results, n_hits);
    if (errors == 0) begin
      $display("ghost_box_rank_lookup_top test passed");
    end else begin
      $display("ghost_box_rank_lookup_top test failed");
    end
    $finish;
  end

endmodule
